// ===== sv/ptp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared widths, codes and types for the peak-to-peak level meter.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int SAMPLE_W = 10;
  localparam int TICK_W   = 16;
  localparam int MIN_W    = SAMPLE_W + 1;
  localparam int CFG_W    = 16;
  localparam int REG_IDX_W = 2;

  localparam logic [MIN_W-1:0] NO_SAMPLE = MIN_W'(1024);

  // floor(m * 14 / 10) == (m * 91756) >> 16 for m < 1024
  localparam int GAIN_SHIFT = 16;
  localparam int GAIN_W     = 17;
  localparam logic [GAIN_W-1:0] GAIN_RECIP = GAIN_W'(91756);
  localparam int SCALE_SHIFT = 10;
  localparam int BAR_RAW_W   = SAMPLE_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_COUNT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STRIP_LENGTH = 2'd2;

  typedef struct packed {
    logic                push;
    logic [SAMPLE_W-1:0] data;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_SCALE = 4'b0010,
    B_GAIN  = 4'b0100,
    B_OUT   = 4'b1000
  } back_state_t;

endpackage
`default_nettype wire

// ===== sv/ptp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_front
// Accepts words, tracks window max/min and tick count, queues the amplitude.
// ----------------------------------------------------------------------------
module ptp_front import ptp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                cmd,
  input  wire logic [SAMPLE_W-1:0] sample_value,
  input  wire logic [TICK_W-1:0]   window_ticks,
  input  wire q_stat_t             q_stat,
  output q_wr_t                    q_wr
);

  logic [SAMPLE_W-1:0] window_max;
  logic [MIN_W-1:0]    window_min;
  logic [TICK_W-1:0]   elapsed_ticks;
  logic [TICK_W-1:0]   elapsed_next;
  logic                accept;
  logic                window_end;
  logic [SAMPLE_W-1:0] amp;

  assign in_ready     = !q_stat.full;
  assign accept       = in_valid && in_ready;
  assign elapsed_next = elapsed_ticks + TICK_W'(1);
  assign window_end   = accept && (cmd == CMD_TICK) && (elapsed_next >= window_ticks);

  always_comb begin
    if (window_min >= NO_SAMPLE || {1'b0, window_max} < window_min) begin
      amp = '0;
    end else begin
      amp = window_max - window_min[SAMPLE_W-1:0];
    end
  end

  assign q_wr.push = window_end;
  assign q_wr.data = amp;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_max    <= '0;
      window_min    <= NO_SAMPLE;
      elapsed_ticks <= '0;
    end else if (accept) begin
      if (cmd == CMD_SAMPLE) begin
        if (sample_value > window_max) begin
          window_max <= sample_value;
        end
        if ({1'b0, sample_value} < window_min) begin
          window_min <= {1'b0, sample_value};
        end
      end else if (window_end) begin
        window_max    <= '0;
        window_min    <= NO_SAMPLE;
        elapsed_ticks <= '0;
      end else begin
        elapsed_ticks <= elapsed_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_queue
// Short FIFO of window amplitudes between front and back.
// ----------------------------------------------------------------------------
module ptp_queue import ptp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire q_wr_t               q_wr,
  input  wire logic                pop,
  output q_stat_t                  q_stat,
  output logic [SAMPLE_W-1:0]      rd_data
);

  logic [SAMPLE_W-1:0] slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign q_stat.valid = (count != '0);
  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push      = q_wr.push && !q_stat.full;
  assign do_pop       = pop && q_stat.valid;
  assign rd_data      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_back
// Maps a queued amplitude to a bar length and holds the result word.
// ----------------------------------------------------------------------------
module ptp_back import ptp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire q_stat_t             q_stat,
  input  wire logic [SAMPLE_W-1:0] rd_data,
  output logic                     pop,
  input  wire logic [SAMPLE_W-1:0] scale_count,
  input  wire logic [SAMPLE_W-1:0] strip_length,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      amplitude,
  output logic [SAMPLE_W-1:0]      bar_length
);

  back_state_t state;
  back_state_t state_next;

  logic [SAMPLE_W-1:0]          amp_r;
  logic [SAMPLE_W-1:0]          mapped;
  logic [BAR_RAW_W-1:0]         bar_raw;
  logic [2*SAMPLE_W-1:0]        scale_prod;
  logic [SAMPLE_W+GAIN_W-1:0]   gain_prod;

  assign scale_prod = amp_r * scale_count;
  assign gain_prod  = mapped * GAIN_RECIP;
  assign pop        = (state == B_IDLE) && q_stat.valid;
  assign out_valid  = (state == B_OUT);
  assign amplitude  = amp_r;

  always_comb begin
    if (bar_raw > {1'b0, strip_length}) begin
      bar_length = strip_length;
    end else begin
      bar_length = bar_raw[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    case (state)
      B_IDLE:  state_next = q_stat.valid ? B_SCALE : B_IDLE;
      B_SCALE: state_next = B_GAIN;
      B_GAIN:  state_next = B_OUT;
      B_OUT:   state_next = out_ready ? B_IDLE : B_OUT;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      amp_r <= rd_data;
    end
    if (state == B_SCALE) begin
      mapped <= scale_prod[2*SAMPLE_W-1:SCALE_SHIFT];
    end
    if (state == B_GAIN) begin
      bar_raw <= gain_prod[GAIN_SHIFT+BAR_RAW_W-1:GAIN_SHIFT];
    end
  end

endmodule
`default_nettype wire

// ===== sv/peak_to_peak_level_meter.sv =====
`default_nettype none
// Flow: the window-ending tick word pushes the amplitude into the queue; the back end pops
// it, registers the scaled value, then the bar length, and then holds the result word valid.
// Throughput: one input word per cycle while the queue is not full; the back end takes a new
// amplitude only after its result word is taken. A 2-entry queue decouples the sides.
// Reset (rst, synchronous): registers to 50/32/32, trackers cleared, queue empty.
// ----------------------------------------------------------------------------
// peak_to_peak_level_meter
// Window peak-to-peak amplitude and LED bar length from a sample/tick stream.
// ----------------------------------------------------------------------------
module peak_to_peak_level_meter import ptp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 cmd,
  input  wire logic [SAMPLE_W-1:0]  sample_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [SAMPLE_W-1:0]       amplitude,
  output logic [SAMPLE_W-1:0]       bar_length
);

  logic [TICK_W-1:0]   window_ticks;
  logic [SAMPLE_W-1:0] scale_count;
  logic [SAMPLE_W-1:0] strip_length;

  q_wr_t               q_wr;
  q_stat_t             q_stat;
  logic                q_pop;
  logic [SAMPLE_W-1:0] q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= TICK_W'(50);
      scale_count  <= SAMPLE_W'(32);
      strip_length <= SAMPLE_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_TICKS: window_ticks <= cfg_data;
        REG_SCALE_COUNT:  scale_count  <= cfg_data[SAMPLE_W-1:0];
        REG_STRIP_LENGTH: strip_length <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  ptp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .sample_value (sample_value),
    .window_ticks (window_ticks),
    .q_stat       (q_stat),
    .q_wr         (q_wr)
  );

  ptp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_wr    (q_wr),
    .pop     (q_pop),
    .q_stat  (q_stat),
    .rd_data (q_data)
  );

  ptp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .rd_data      (q_data),
    .pop          (q_pop),
    .scale_count  (scale_count),
    .strip_length (strip_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .amplitude    (amplitude),
    .bar_length   (bar_length)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_wr.push && q_stat.full))
    else $error("window result pushed into full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_stat.valid)
    else $error("queue popped while empty");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(amplitude) && $stable(bar_length)))
    else $error("stalled result word changed");

  a_bar_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bar_length <= strip_length))
    else $error("bar length above strip length");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_peak_to_peak_level_meter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_peak_to_peak_level_meter
// Self-checking bench for the peak-to-peak level meter. A cycle model tracks
// window max/min and tick count for every accepted word and queues the
// expected amplitude and bar length; each result word is checked in order.
// Directed windows cover reset values, empty windows, independent min/max,
// saturation, zero scale/strip and odd register writes; then a long stall on
// the result side, randomized windows and one long window.
// ----------------------------------------------------------------------------
module tb_peak_to_peak_level_meter;
  import ptp_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAP_SPAN      = 1024;
  localparam int GAIN_NUM      = 14;
  localparam int GAIN_DEN      = 10;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] amp;
    logic [SAMPLE_W-1:0] bar;
  } level_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 cmd = CMD_SAMPLE;
  logic [SAMPLE_W-1:0]  sample_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SAMPLE_W-1:0]  amplitude;
  logic [SAMPLE_W-1:0]  bar_length;

  level_t expected_levels[$];
  int     fail_count = 0;
  bit     send_idle = 1'b1;
  bit     recv_idle = 1'b1;
  bit     hold_req = 1'b0;

  peak_to_peak_level_meter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .sample_value (sample_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .amplitude    (amplitude),
    .bar_length   (bar_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SAMPLE_W'($urandom);
  endfunction

  // ---- level model ----
  always @(posedge clk) begin : level_model
    logic [TICK_W-1:0]   win_len;
    logic [SAMPLE_W-1:0] scale_cnt;
    logic [SAMPLE_W-1:0] strip_len;
    logic [SAMPLE_W-1:0] trk_max;
    logic [MIN_W-1:0]    trk_min;
    logic [TICK_W-1:0]   trk_ticks;
    int unsigned         amp_i;
    int unsigned         mapped;
    int unsigned         bar_i;
    if (rst) begin
      win_len   = 16'd50;
      scale_cnt = 10'd32;
      strip_len = 10'd32;
      trk_max   = '0;
      trk_min   = NO_SAMPLE;
      trk_ticks = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_TICKS: win_len   = cfg_data[TICK_W-1:0];
          REG_SCALE_COUNT:  scale_cnt = cfg_data[SAMPLE_W-1:0];
          REG_STRIP_LENGTH: strip_len = cfg_data[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (cmd == CMD_SAMPLE) begin
          if (sample_value > trk_max) trk_max = sample_value;
          if (sample_value < trk_min) trk_min = sample_value;
        end else begin
          trk_ticks = trk_ticks + 16'd1;
          if (trk_ticks >= win_len) begin
            if (trk_min >= NO_SAMPLE || trk_max < trk_min) amp_i = 0;
            else amp_i = trk_max - trk_min[SAMPLE_W-1:0];
            mapped = amp_i * scale_cnt / MAP_SPAN;
            bar_i  = mapped * GAIN_NUM / GAIN_DEN;
            if (bar_i > strip_len) bar_i = strip_len;
            expected_levels.push_back('{amp: SAMPLE_W'(amp_i), bar: SAMPLE_W'(bar_i)});
            trk_max   = '0;
            trk_min   = NO_SAMPLE;
            trk_ticks = '0;
          end
        end
      end
    end
  end

  // ---- result check ----
  always @(posedge clk) begin : level_check
    level_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        $error("unexpected result word: amplitude %0d bar_length %0d", amplitude, bar_length);
        fail_count++;
      end else begin
        want = expected_levels.pop_front();
        if (amplitude !== want.amp) begin
          $error("amplitude: expected %0d, actual %0d", want.amp, amplitude);
          fail_count++;
        end
        if (bar_length !== want.bar) begin
          $error("bar_length: expected %0d, actual %0d", want.bar, bar_length);
          fail_count++;
        end
      end
    end
  end

  // ---- result side flow control ----
  always @(posedge clk) begin : result_sink
    int hold_left;
    int stall_left;
    int g;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      g = recv_idle ? pick_gap() : 0;
      if (g > 0) begin
        stall_left = g - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_peak_to_peak_level_meter NOT OK");
      $finish;
    end
  end

  // ---- stimulus ----
  task automatic send_word(input logic kind, input logic [SAMPLE_W-1:0] value);
    int g;
    in_valid     <= 1'b1;
    cmd          <= kind;
    sample_value <= value;
    do @(posedge clk); while (!in_ready);
    g = send_idle ? pick_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, SAMPLE_W'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_levels(input logic [TICK_W-1:0] win, input logic [SAMPLE_W-1:0] scale,
                            input logic [SAMPLE_W-1:0] strip);
    write_reg(REG_WINDOW_TICKS, win);
    write_reg(REG_SCALE_COUNT, {6'($urandom), scale});
    write_reg(REG_STRIP_LENGTH, {6'($urandom), strip});
  endtask

  // default 50-tick window, default scale and strip
  task automatic test_reset_values();
    send_word(CMD_SAMPLE, 10'd0);
    send_word(CMD_SAMPLE, 10'd1023);
    repeat (50) send_tick();
    send_word(CMD_SAMPLE, 10'd700);
    send_word(CMD_SAMPLE, 10'd0);
    repeat (50) send_tick();
  endtask

  task automatic test_directed();
    set_levels(16'd1, 10'd1023, 10'd1023);
    send_tick();                              // empty window
    send_word(CMD_SAMPLE, 10'd512);
    send_tick();                              // single sample
    send_word(CMD_SAMPLE, 10'd100);
    send_word(CMD_SAMPLE, 10'd300);
    send_word(CMD_SAMPLE, 10'd200);
    send_tick();                              // min and max move separately
    send_word(CMD_SAMPLE, 10'd900);
    send_word(CMD_SAMPLE, 10'd5);
    send_tick();
    send_word(CMD_SAMPLE, 10'd0);
    send_word(CMD_SAMPLE, 10'd1023);
    send_tick();                              // full swing, bar saturates
    write_reg(REG_SCALE_COUNT, 16'd0);
    send_word(CMD_SAMPLE, 10'd0);
    send_word(CMD_SAMPLE, 10'd1023);
    send_tick();
    write_reg(REG_SCALE_COUNT, 16'd1023);
    write_reg(REG_STRIP_LENGTH, 16'd0);
    send_word(CMD_SAMPLE, 10'd3);
    send_word(CMD_SAMPLE, 10'd700);
    send_tick();
    write_reg(REG_STRIP_LENGTH, 16'd1023);
    write_reg(REG_UNUSED, 16'hFFFF);          // no register there
    send_word(CMD_SAMPLE, 10'd341);
    send_tick();
    write_reg(REG_WINDOW_TICKS, 16'd0);       // every tick closes a window
    send_tick();
    send_word(CMD_SAMPLE, 10'd682);
    send_tick();
    write_reg(REG_WINDOW_TICKS, 16'd5);
    send_word(CMD_SAMPLE, 10'd20);
    repeat (3) send_tick();
    write_reg(REG_WINDOW_TICKS, 16'd2);       // shrink below elapsed count
    send_word(CMD_SAMPLE, 10'd640);
    send_tick();
  endtask

  // result side held off while ticks keep closing windows
  task automatic test_output_backpressure();
    set_levels(16'd1, 10'd1023, 10'd1023);
    send_idle = 1'b0;
    hold_req  = 1'b1;
    repeat (12) begin
      send_word(CMD_SAMPLE, rand_sample());
      send_tick();
    end
    send_idle = 1'b1;
  endtask

  task automatic test_random_windows();
    logic [TICK_W-1:0]   win;
    logic [SAMPLE_W-1:0] scale;
    logic [SAMPLE_W-1:0] strip;
    int                  sent;
    int                  n;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       begin win = 16'd1; scale = 10'd1023; strip = 10'd1023; end
        1:       begin win = 16'd2; scale = 10'd0;    strip = 10'd1023; end
        2:       begin win = 16'd3; scale = 10'd1023; strip = 10'd0;    end
        3:       begin win = 16'd1; scale = 10'd512;  strip = 10'd1023; end
        default: begin
          win   = TICK_W'($urandom_range(1, 4));
          scale = SAMPLE_W'($urandom);
          strip = SAMPLE_W'($urandom);
        end
      endcase
      set_levels(win, scale, strip);
      recv_idle = (ph != 4);
      sent = 0;
      while (sent < 80) begin
        send_idle = ($urandom_range(0, 3) != 0);
        n = $urandom_range(0, 6);
        repeat (n) send_word(CMD_SAMPLE, rand_sample());
        send_tick();
        sent += n + 1;
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_long_window();
    set_levels(16'd256, 10'd1023, 10'd1023);
    send_idle = 1'b0;
    for (int i = 0; i < 256; i++) begin
      if (i % 64 == 0) send_word(CMD_SAMPLE, rand_sample());
      send_tick();
    end
    send_idle = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_output_backpressure();
    test_random_windows();
    test_long_window();
    wait_drained();
    if (fail_count == 0) begin
      $display("tb_peak_to_peak_level_meter OK");
    end else begin
      $display("tb_peak_to_peak_level_meter NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/ptp_pkg.sv
sv/ptp_front.sv
sv/ptp_queue.sv
sv/ptp_back.sv
sv/peak_to_peak_level_meter.sv
tb/sv/tb_peak_to_peak_level_meter.sv
